// ===== design/first_fit_heap_allocator_assert.svh =====
// Assertion macros for the first-fit heap allocator checker.
// Included by the checker; needs nothing else.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FFHA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FFHA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/ffha_pkg.sv =====
// Shared types and codes of the first-fit heap allocator.
// Depends on nothing; used by the controller, the datapath and the top level.
`default_nettype none

package ffha_pkg;

   localparam int SIZE_BITS   = 20;
   localparam int STATUS_BITS = 2;

   localparam logic [SIZE_BITS-1:0] HEAP_RESET = 20'd65536;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_NO_FIT    = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_NOT_FOUND = 2'd2;

   // table read port selection
   localparam logic [1:0] RD_SCAN = 2'd0;
   localparam logic [1:0] RD_NEXT = 2'd1;
   localparam logic [1:0] RD_PREV = 2'd2;

   typedef struct packed {
      logic [1:0] rd_sel;
      logic       load;
      logic       step;
      logic       take;
      logic       fail;
      logic       alloc;
      logic       merge_next;
      logic       merge_prev;
      logic       free_done;
   } ffha_cmd_type;

   typedef struct packed {
      logic is_free;
      logic scan_end;
      logic hit;
      logic split;
      logic full;
      logic nbr_free;
   } ffha_stat_type;

endpackage

`default_nettype wire

// ===== design/ffha_ctrl.sv =====
// Sequencer of the first-fit heap allocator: scan, allocate, merge.
// Depends on ffha_pkg.
`default_nettype none

module ffha_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire ffha_pkg::ffha_stat_type stat,
   output ffha_pkg::ffha_cmd_type      cmd
);
   import ffha_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_ALLOC = 3'd2;
   localparam logic [2:0] S_MNEXT = 3'd3;
   localparam logic [2:0] S_MPREV = 3'd4;

   logic [2:0] state_ff, state_in;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      cmd      = '0;
      cmd.rd_sel = RD_SCAN;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (stat.scan_end) begin
               cmd.fail = 1'b1;
               state_in = S_IDLE;
            end else if (stat.hit) begin
               cmd.take = 1'b1;
               state_in = stat.is_free ? S_MNEXT : S_ALLOC;
            end else begin
               cmd.step = 1'b1;
            end
         end
         S_ALLOC: begin
            if (stat.split && stat.full) cmd.fail = 1'b1;
            else                         cmd.alloc = 1'b1;
            state_in = S_IDLE;
         end
         S_MNEXT: begin
            cmd.rd_sel = RD_NEXT;
            if (stat.nbr_free) cmd.merge_next = 1'b1;
            else               state_in = S_MPREV;
         end
         S_MPREV: begin
            cmd.rd_sel = RD_PREV;
            if (stat.nbr_free) begin
               cmd.merge_prev = 1'b1;
            end else begin
               cmd.free_done = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

`default_nettype wire

// ===== design/ffha_dpath.sv =====
// Block table and arithmetic of the first-fit heap allocator.
// Depends on ffha_pkg; driven by ffha_ctrl.
`default_nettype none

module ffha_dpath #(
   parameter int MAX_BLOCKS   = 32,
   parameter int HEADER_BYTES = 20,
   parameter int ADDR_BITS    = 20
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire ffha_pkg::ffha_cmd_type              cmd,
   output ffha_pkg::ffha_stat_type                  stat,
   input  wire logic                                req_func,
   input  wire logic [ffha_pkg::SIZE_BITS-1:0]      req_operand_value,
   input  wire logic                                csr_we,
   input  wire logic [ffha_pkg::SIZE_BITS-1:0]      csr_heap_size,
   output logic                                     rsp_valid,
   output logic [ffha_pkg::STATUS_BITS-1:0]         rsp_status,
   output logic [ffha_pkg::SIZE_BITS-1:0]           rsp_result_address
);
   import ffha_pkg::*;

   localparam int KW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam logic [SIZE_BITS-1:0] HDR_SZ = SIZE_BITS'(HEADER_BYTES);
   localparam logic [ADDR_BITS-1:0] HDR_AD = ADDR_BITS'(HEADER_BYTES);
   localparam logic [CW-1:0]        MAX_CNT = CW'(MAX_BLOCKS);

   logic [ADDR_BITS-1:0] off_ff   [MAX_BLOCKS];
   logic [ADDR_BITS-1:0] off_in   [MAX_BLOCKS];
   logic [SIZE_BITS-1:0] bytes_ff [MAX_BLOCKS];
   logic [SIZE_BITS-1:0] bytes_in [MAX_BLOCKS];
   logic [MAX_BLOCKS-1:0] used_ff, used_in;
   logic [CW-1:0] total_ff, total_in, idx_ff, idx_in;
   logic [KW-1:0] k_ff, k_in, rd_addr;
   logic          func_ff, func_in;
   logic [SIZE_BITS-1:0] opv_ff, opv_in;
   logic [ADDR_BITS-1:0] cur_off_ff, cur_off_in;
   logic [SIZE_BITS-1:0] cur_bytes_ff, cur_bytes_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;
   logic [SIZE_BITS-1:0]   rsp_addr_ff, rsp_addr_in;

   logic [ADDR_BITS-1:0] off_rd;
   logic [SIZE_BITS-1:0] bytes_rd, rest, merged;
   logic                 used_rd;
   logic [CW-1:0]        k_cnt;

   function automatic logic [SIZE_BITS-1:0] init_bytes(input logic [SIZE_BITS-1:0] heap);
      init_bytes = (heap >= HDR_SZ) ? (heap - HDR_SZ) : '0;
   endfunction

   // single table read port
   always_comb begin
      unique case (cmd.rd_sel)
         RD_NEXT: rd_addr = k_ff + KW'(1);
         RD_PREV: rd_addr = k_ff - KW'(1);
         default: rd_addr = idx_ff[KW-1:0];
      endcase
   end

   assign off_rd   = off_ff[rd_addr];
   assign bytes_rd = bytes_ff[rd_addr];
   assign used_rd  = used_ff[rd_addr];
   assign k_cnt    = CW'(k_ff);
   assign rest     = cur_bytes_ff - opv_ff;
   assign merged   = cur_bytes_ff + bytes_rd + HDR_SZ;

   always_comb begin
      stat.is_free  = (func_ff == FUNC_FREE);
      stat.scan_end = (idx_ff >= total_ff);
      if (func_ff == FUNC_FREE)
         stat.hit = used_rd && ((off_rd + HDR_AD) == ADDR_BITS'(opv_ff));
      else
         stat.hit = !used_rd && (bytes_rd >= opv_ff);
      stat.split = (rest >= HDR_SZ);
      stat.full  = (total_ff >= MAX_CNT);
      if (cmd.rd_sel == RD_NEXT) stat.nbr_free = ((k_cnt + CW'(1)) < total_ff) && !used_rd;
      else                       stat.nbr_free = (k_ff != '0) && !used_rd;
   end

   always_comb begin
      off_in        = off_ff;
      bytes_in      = bytes_ff;
      used_in       = used_ff;
      total_in      = total_ff;
      idx_in        = idx_ff;
      k_in          = k_ff;
      func_in       = func_ff;
      opv_in        = opv_ff;
      cur_off_in    = cur_off_ff;
      cur_bytes_in  = cur_bytes_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;

      if (csr_we) begin
         for (int i = 0; i < MAX_BLOCKS; i++) begin
            off_in[i]   = '0;
            bytes_in[i] = '0;
         end
         bytes_in[0] = init_bytes(csr_heap_size);
         used_in     = '0;
         total_in    = CW'(1);
      end

      if (cmd.load) begin
         func_in = req_func;
         opv_in  = req_operand_value;
         idx_in  = '0;
      end
      if (cmd.step) idx_in = idx_ff + CW'(1);
      if (cmd.take) begin
         k_in         = rd_addr;
         cur_off_in   = off_rd;
         cur_bytes_in = bytes_rd;
         if (func_ff == FUNC_FREE) used_in[rd_addr] = 1'b0;
      end
      if (cmd.fail) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = (func_ff == FUNC_FREE) ? STATUS_NOT_FOUND : STATUS_NO_FIT;
         rsp_addr_in   = '0;
      end
      if (cmd.alloc) begin
         if (stat.split) begin
            for (int i = 0; i < MAX_BLOCKS; i++) begin
               if (CW'(i) > k_cnt + CW'(1)) begin
                  off_in[i]   = off_ff[i-1];
                  bytes_in[i] = bytes_ff[i-1];
                  used_in[i]  = used_ff[i-1];
               end else if (CW'(i) == k_cnt + CW'(1)) begin
                  off_in[i]   = cur_off_ff + HDR_AD + ADDR_BITS'(opv_ff);
                  bytes_in[i] = rest - HDR_SZ;
                  used_in[i]  = 1'b0;
               end
            end
            bytes_in[k_ff] = opv_ff;
            total_in       = total_ff + CW'(1);
         end
         used_in[k_ff] = 1'b1;
         rsp_valid_in  = 1'b1;
         rsp_status_in = STATUS_OK;
         rsp_addr_in   = SIZE_BITS'(cur_off_ff + HDR_AD);
      end
      if (cmd.merge_next || cmd.merge_prev) begin
         // drop entry k+1 (next) or k (prev), the survivor takes the merged size
         for (int i = 0; i < MAX_BLOCKS; i++) begin
            if ((cmd.merge_next && CW'(i) > k_cnt) || (cmd.merge_prev && CW'(i) >= k_cnt)) begin
               if (i < MAX_BLOCKS - 1) begin
                  off_in[i]   = off_ff[i+1];
                  bytes_in[i] = bytes_ff[i+1];
                  used_in[i]  = used_ff[i+1];
               end else begin
                  off_in[i]   = '0;
                  bytes_in[i] = '0;
                  used_in[i]  = 1'b0;
               end
            end
         end
         if (cmd.merge_next) begin
            bytes_in[k_ff] = merged;
         end else begin
            bytes_in[rd_addr] = merged;
            k_in = rd_addr;
         end
         cur_bytes_in = merged;
         total_in     = total_ff - CW'(1);
      end
      if (cmd.free_done) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = STATUS_OK;
         rsp_addr_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_BLOCKS; i++) begin
            off_ff[i]   <= '0;
            bytes_ff[i] <= '0;
         end
         bytes_ff[0]  <= init_bytes(HEAP_RESET);
         used_ff      <= '0;
         total_ff     <= CW'(1);
         idx_ff       <= '0;
         k_ff         <= '0;
         func_ff      <= FUNC_ALLOC;
         rsp_valid_ff <= 1'b0;
      end else begin
         off_ff       <= off_in;
         bytes_ff     <= bytes_in;
         used_ff      <= used_in;
         total_ff     <= total_in;
         idx_ff       <= idx_in;
         k_ff         <= k_in;
         func_ff      <= func_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      opv_ff        <= opv_in;
      cur_off_ff    <= cur_off_in;
      cur_bytes_ff  <= cur_bytes_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_result_address = rsp_addr_ff;

endmodule

`default_nettype wire

// ===== design/first_fit_heap_allocator.sv =====
// Top level of the first-fit heap allocator: controller plus table datapath.
// Depends on ffha_pkg, ffha_ctrl and ffha_dpath.
`default_nettype none

// First-fit heap allocator with coalescing. Issue a request by raising start
// with req_func (allocate or free) and req_operand_value while busy is low;
// the request is transferred at that edge and busy rises. The answer appears on
// rsp_status and rsp_result_address for exactly one cycle, flagged by
// rsp_valid, and cannot be held off by the receiver: capture it when it comes.
// A request scans the table entries from the first up to the hit; an allocate
// then takes the found block, splitting off the rest when it can hold a header
// (no fit if the table is already full), and a free merges the block with a free
// next neighbour and then with a free previous one. A request that finds
// nothing scans all valid entries (at most MAX_BLOCKS), one entry per cycle
// through the table's single read port. The result is registered.
// Write heap_size through the csr_ channel only while busy is low and no
// answer is pending: the write reloads the table with one free block at once.
// csr_ready is always high.
module first_fit_heap_allocator #(
   parameter int MAX_BLOCKS   = 32,
   parameter int HEADER_BYTES = 20,
   parameter int ADDR_BITS    = 20
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic                              req_func,
   input  wire logic [ffha_pkg::SIZE_BITS-1:0]    req_operand_value,
   output logic                                   rsp_valid,
   output logic [ffha_pkg::STATUS_BITS-1:0]       rsp_status,
   output logic [ffha_pkg::SIZE_BITS-1:0]         rsp_result_address,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [ffha_pkg::SIZE_BITS-1:0]    csr_heap_size
);
   import ffha_pkg::*;

   ffha_cmd_type  cmd;
   ffha_stat_type stat;
   logic          accept;

   // accept config at any time; the user keeps it to idle periods
   assign csr_ready = 1'b1;
   // the controller only sees start while idle, so gate it here as well
   assign accept    = start && !busy;

   ffha_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   ffha_dpath #(
      .MAX_BLOCKS   (MAX_BLOCKS),
      .HEADER_BYTES (HEADER_BYTES),
      .ADDR_BITS    (ADDR_BITS)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_func           (req_func),
      .req_operand_value  (req_operand_value),
      .csr_we             (csr_valid && csr_ready),
      .csr_heap_size      (csr_heap_size),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_result_address (rsp_result_address)
   );

endmodule

`default_nettype wire

// ===== design/ffha_checker.sv =====
// Port-level checks of the first-fit heap allocator, bound to the top level.
// Depends on ffha_pkg and first_fit_heap_allocator_assert.svh.
`default_nettype none

`include "first_fit_heap_allocator_assert.svh"

module ffha_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              start,
   input wire logic                              busy,
   input wire logic                              rsp_valid,
   input wire logic [ffha_pkg::STATUS_BITS-1:0]  rsp_status,
   input wire logic [ffha_pkg::SIZE_BITS-1:0]    rsp_result_address
);
   import ffha_pkg::*;

   `FFHA_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "busy missing after transfer")
   `FFHA_ASSERT_NEXT(a_single_pulse, clock, reset, rsp_valid, !rsp_valid, "answer strobe repeated")
   `FFHA_ASSERT_NOW(a_answer_after_busy, clock, reset, rsp_valid, $past(busy) && !busy, "answer without request")
   `FFHA_ASSERT_NOW(a_fail_zero, clock, reset, rsp_valid && rsp_status != STATUS_OK, rsp_result_address == '0, "address on failure")
   `FFHA_ASSERT_NOW(a_status_code, clock, reset, rsp_valid, rsp_status == STATUS_OK || rsp_status == STATUS_NO_FIT || rsp_status == STATUS_NOT_FOUND, "bad status")

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (.*);

`default_nettype wire
